// File: rtl/hpc_pkg.sv
// Shared constants, codes and helper functions for the HTTP packet classifier.
package hpc_pkg;

  localparam int POSITION_BITS_DEF = 16;

  localparam int ETH_LEN  = 14;
  localparam int WIN_LEN  = 18;
  localparam int HEAD_LEN = 6;

  localparam int POS_ETYPE_HI = 12;
  localparam int POS_ETYPE_LO = 13;
  localparam int POS_IHL      = 14;
  localparam int POS_PROTO    = 23;
  localparam int POS_SRC_IP   = 26;
  localparam int POS_DST_IP   = 30;
  localparam int L4_OFF_DOFF  = 12;
  localparam int L4_MIN_LONG  = 16;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;

  localparam int OUT_DATA_BITS = 184;

  typedef enum logic [2:0] {
    VERDICT_NOT_IPV4   = 3'd0,
    VERDICT_WRONG_L4   = 3'd1,
    VERDICT_NO_PAYLOAD = 3'd2,
    VERDICT_NOT_FLAG   = 3'd3,
    VERDICT_REQUEST    = 3'd4,
    VERDICT_RESPONSE   = 3'd5
  } verdict_t;

  typedef enum logic [2:0] {
    METHOD_NONE   = 3'd0,
    METHOD_GET    = 3'd1,
    METHOD_PUT    = 3'd2,
    METHOD_POST   = 3'd3,
    METHOD_DELETE = 3'd4
  } method_t;

  typedef enum logic [1:0] {
    CFG_TRANSPORT = 2'd0,
    CFG_HTTP_EN   = 2'd1,
    CFG_METHOD    = 2'd2
  } cfg_index_t;

  typedef logic [7:0] head_t [HEAD_LEN];

  function automatic method_t detect_method(input head_t h);
    method_t m;
    m = METHOD_NONE;
    if (h[0] == "G" && h[1] == "E" && h[2] == "T") begin
      m = METHOD_GET;
    end else if (h[0] == "P" && h[1] == "U" && h[2] == "T") begin
      m = METHOD_PUT;
    end else if (h[0] == "P" && h[1] == "O" && h[2] == "S" && h[3] == "T") begin
      m = METHOD_POST;
    end else if (h[0] == "D" && h[1] == "E" && h[2] == "L" && h[3] == "E" &&
                 h[4] == "T" && h[5] == "E") begin
      m = METHOD_DELETE;
    end
    return m;
  endfunction

  function automatic logic is_response(input head_t h);
    return h[0] == "H" && h[1] == "T" && h[2] == "T" && h[3] == "P";
  endfunction

endpackage

// File: rtl/http_packet_classifier_unit.sv
// Top level of the HTTP packet classifier: byte-stream frame parser and verdict generator.
//
// Frame bytes enter on the in_ stream starting at the Ethernet destination address, one
// byte per transaction, with in_tlast on the final captured byte. Each byte is captured in
// an input register and handled in the following cycle by compare-and-capture logic, so one
// byte is taken every cycle; the only wait comes from a pending verdict that the out_ side
// has not yet taken. The byte with in_tlast produces exactly one verdict transaction through
// the input and result registers; other bytes produce none. Bytes a frame lacks read as zero.
// Configuration writes (cfg_index 0 transport, 1 HTTP enable, 2 method filter) are always
// ready and should be issued only while no frame is in flight.
module http_packet_classifier_unit
  import hpc_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // tdata: [7:0] byte_value
  input  logic [7:0]               in_tdata,
  input  logic                     in_tlast,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // tdata: [2:0] verdict, [5:3] method_code, [37:6] source_ip, [69:38] dest_ip,
  //        [85:70] source_l4_port, [101:86] dest_l4_port, [117:102] payload_bytes,
  //        [149:118] packet_number, [181:150] flagged_total, [183:182] zero
  output logic [OUT_DATA_BITS-1:0] out_tdata,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [2:0]               cfg_data
);

  localparam int PB = POSITION_BITS;
  localparam int LW = (PB > 16) ? PB : 16;

  // configuration
  logic       transport_r;
  logic       http_en_r;
  logic [2:0] method_filter_r;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // frame state
  logic [PB-1:0] pos_r, pos_nxt;
  logic [15:0]   ek_r, ek_nxt;
  logic [5:0]    ihb_r, ihb_nxt;
  logic [7:0]    proto_r, proto_nxt;
  logic [5:0]    l4_r, l4_nxt;
  logic [31:0]   sip_r, sip_nxt;
  logic [31:0]   dip_r, dip_nxt;
  logic [15:0]   sp_r, sp_nxt;
  logic [15:0]   dp_r, dp_nxt;
  logic [7:0]    win_r [WIN_LEN];
  logic [7:0]    win_nxt [WIN_LEN];
  head_t         head_r, head_nxt;
  logic [31:0]   acc_cnt_r, acc_cnt_nxt;
  logic [31:0]   flag_cnt_r, flag_cnt_nxt;

  // result register
  logic                     out_valid_r;
  logic [OUT_DATA_BITS-1:0] out_data_r, out_data_nxt;

  logic out_free, s1_fire;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && (!s1_last_r || out_free);
  assign in_tready = !s1_valid_r || s1_fire;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  logic [6:0]    l4_start;
  logic [PB-1:0] start_p, win_off, pay_start, pay_off;
  logic          in_win, in_pay;
  head_t         head_fin;
  logic [4:0]    win_base;
  logic [7:0]    headers;
  logic [PB-1:0] plen;
  logic [LW-1:0] plen_w;
  logic [15:0]   pbytes;
  logic [7:0]    want;
  method_t       method;
  verdict_t      verdict;
  logic          accepted;

  always_comb begin
    pos_nxt   = pos_r;
    ek_nxt    = ek_r;
    ihb_nxt   = ihb_r;
    proto_nxt = proto_r;
    l4_nxt    = l4_r;
    sip_nxt   = sip_r;
    dip_nxt   = dip_r;
    sp_nxt    = sp_r;
    dp_nxt    = dp_r;
    win_nxt   = win_r;
    head_nxt  = head_r;

    if (pos_r == PB'(POS_ETYPE_HI)) ek_nxt[15:8] = s1_byte_r;
    if (pos_r == PB'(POS_ETYPE_LO)) ek_nxt[7:0]  = s1_byte_r;
    if (pos_r == PB'(POS_IHL))      ihb_nxt = {s1_byte_r[3:0], 2'b00};
    if (pos_r == PB'(POS_PROTO))    proto_nxt = s1_byte_r;
    if (pos_r >= PB'(POS_SRC_IP) && pos_r < PB'(POS_SRC_IP + 4)) begin
      sip_nxt = {sip_r[23:0], s1_byte_r};
    end
    if (pos_r >= PB'(POS_DST_IP) && pos_r < PB'(POS_DST_IP + 4)) begin
      dip_nxt = {dip_r[23:0], s1_byte_r};
    end

    // layer-4 window: first bytes after the IP header
    l4_start = 7'(ETH_LEN) + {1'b0, ihb_nxt};
    start_p  = PB'(l4_start);
    win_off  = pos_r - start_p;
    in_win   = (pos_r >= start_p) && (win_off < PB'(WIN_LEN));
    if (in_win) begin
      win_nxt[win_off[4:0]] = s1_byte_r;
      if (win_off == PB'(0)) sp_nxt[15:8] = s1_byte_r;
      if (win_off == PB'(1)) sp_nxt[7:0]  = s1_byte_r;
      if (win_off == PB'(2)) dp_nxt[15:8] = s1_byte_r;
      if (win_off == PB'(3)) dp_nxt[7:0]  = s1_byte_r;
      if (win_off == PB'(L4_OFF_DOFF)) l4_nxt = {s1_byte_r[7:4], 2'b00};
    end

    // payload head when it lies past the window
    pay_start = start_p + PB'(l4_nxt);
    pay_off   = pos_r - pay_start;
    in_pay    = (l4_nxt >= 6'(L4_MIN_LONG)) && (pos_r >= pay_start) &&
                (pay_off < PB'(HEAD_LEN));
    if (in_pay) head_nxt[pay_off[2:0]] = s1_byte_r;

    if (pos_r != {PB{1'b1}}) pos_nxt = pos_r + PB'(1);

    // short layer-4 header: payload starts inside the window
    win_base = {1'b0, l4_nxt[3:2], 2'b00};
    for (int k = 0; k < HEAD_LEN; k++) begin
      head_fin[k] = (l4_nxt < 6'(L4_MIN_LONG)) ? win_nxt[win_base + 5'(k)] : head_nxt[k];
    end

    headers = 8'(ETH_LEN) + {2'b00, ihb_nxt} + {2'b00, l4_nxt};
    plen    = (pos_nxt > PB'(headers)) ? (pos_nxt - PB'(headers)) : '0;
    plen_w  = LW'(plen);
    pbytes  = (plen_w > LW'(16'hFFFF)) ? 16'hFFFF : plen_w[15:0];

    want     = transport_r ? PROTO_UDP : PROTO_TCP;
    method   = METHOD_NONE;
    accepted = 1'b0;
    flag_cnt_nxt = flag_cnt_r;
    if (ek_nxt != ETYPE_IPV4) begin
      verdict = VERDICT_NOT_IPV4;
    end else if (proto_nxt != want) begin
      verdict = VERDICT_WRONG_L4;
    end else begin
      accepted = 1'b1;
      if (plen == '0) begin
        verdict = VERDICT_NO_PAYLOAD;
      end else if (!http_en_r) begin
        verdict = VERDICT_NOT_FLAG;
      end else begin
        method  = detect_method(head_fin);
        verdict = VERDICT_NOT_FLAG;
        if (method != METHOD_NONE &&
            (method_filter_r == 3'(METHOD_NONE) || method_filter_r == 3'(method))) begin
          verdict = VERDICT_REQUEST;
        end
        if (is_response(head_fin)) verdict = VERDICT_RESPONSE;
        if (verdict == VERDICT_REQUEST || verdict == VERDICT_RESPONSE) begin
          flag_cnt_nxt = flag_cnt_r + 32'd1;
        end
      end
    end
    acc_cnt_nxt = accepted ? acc_cnt_r + 32'd1 : acc_cnt_r;

    out_data_nxt = '0;
    out_data_nxt[2:0]     = verdict;
    out_data_nxt[5:3]     = method;
    out_data_nxt[149:118] = accepted ? acc_cnt_r : 32'd0;
    out_data_nxt[181:150] = flag_cnt_nxt;
    if (accepted) begin
      out_data_nxt[37:6]    = sip_nxt;
      out_data_nxt[69:38]   = dip_nxt;
      out_data_nxt[85:70]   = sp_nxt;
      out_data_nxt[101:86]  = dp_nxt;
      out_data_nxt[117:102] = pbytes;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      transport_r     <= 1'b0;
      http_en_r       <= 1'b0;
      method_filter_r <= 3'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TRANSPORT: transport_r     <= cfg_data[0];
        CFG_HTTP_EN:   http_en_r       <= cfg_data[0];
        CFG_METHOD:    method_filter_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (s1_fire && s1_last_r)) begin
      // clear frame state after reset and after every closing byte
      pos_r   <= '0;
      ek_r    <= '0;
      ihb_r   <= '0;
      proto_r <= '0;
      l4_r    <= '0;
      sip_r   <= '0;
      dip_r   <= '0;
      sp_r    <= '0;
      dp_r    <= '0;
      for (int i = 0; i < WIN_LEN; i++) win_r[i] <= '0;
      for (int i = 0; i < HEAD_LEN; i++) head_r[i] <= '0;
    end else if (s1_fire) begin
      pos_r   <= pos_nxt;
      ek_r    <= ek_nxt;
      ihb_r   <= ihb_nxt;
      proto_r <= proto_nxt;
      l4_r    <= l4_nxt;
      sip_r   <= sip_nxt;
      dip_r   <= dip_nxt;
      sp_r    <= sp_nxt;
      dp_r    <= dp_nxt;
      win_r   <= win_nxt;
      head_r  <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_cnt_r  <= 32'd1;
      flag_cnt_r <= 32'd0;
    end else if (s1_fire && s1_last_r) begin
      acc_cnt_r  <= acc_cnt_nxt;
      flag_cnt_r <= flag_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) out_data_r <= out_data_nxt;
  end

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the HTTP packet classifier: byte-stream frames in, verdicts out.
module testbench;
  import hpc_pkg::*;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int DRAIN_CYCLES = 8;

  localparam logic [2:0] FILTER_ALL = 3'd0;
  localparam logic [2:0] FILTER_OFF = 3'd7;  // matches no method

  typedef enum int {
    TEXT_RANDOM, TEXT_GET, TEXT_PUT, TEXT_POST, TEXT_DELETE, TEXT_HTTP, TEXT_NEAR
  } payload_kind_t;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } stream_byte_t;

  typedef struct packed {
    logic [31:0] flagged;
    logic [31:0] packet_num;
    logic [15:0] payload_len;
    logic [15:0] dst_port;
    logic [15:0] src_port;
    logic [31:0] dst_ip;
    logic [31:0] src_ip;
    method_t     method;
    verdict_t    verdict;
  } verdict_rec_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic [7:0]               in_tdata = '0;
  logic                     in_tlast = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [1:0]               cfg_index = '0;
  logic [2:0]               cfg_data = '0;

  http_packet_classifier_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Frame parser state, mirrored byte by byte
  logic [POSITION_BITS_DEF-1:0] frame_pos;
  logic [15:0]                  eth_kind;
  int unsigned                  ip_hdr_len;
  int unsigned                  l4_hdr_len;
  logic [7:0]                   ip_proto;
  logic [31:0]                  src_ip;
  logic [31:0]                  dst_ip;
  logic [15:0]                  src_port;
  logic [15:0]                  dst_port;
  logic [7:0]                   pay_head [HEAD_LEN];
  logic [7:0]                   l4_win [WIN_LEN];
  logic [31:0]                  accepted_num = 32'd1;
  logic [31:0]                  flagged_num = 32'd0;
  logic                         sel_udp = 1'b0;
  logic                         http_on = 1'b0;
  logic [2:0]                   filter_code = FILTER_ALL;

  stream_byte_t pending_bytes [$];
  verdict_rec_t expected_verdicts [$];
  logic [7:0]   frame_buf [$];
  stream_byte_t next_byte;
  int unsigned  queued_bytes = 0;
  int unsigned  accepted_bytes = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void clear_frame_state();
    frame_pos  = '0;
    eth_kind   = '0;
    ip_hdr_len = 0;
    l4_hdr_len = 0;
    ip_proto   = '0;
    src_ip     = '0;
    dst_ip     = '0;
    src_port   = '0;
    dst_port   = '0;
    foreach (pay_head[k]) pay_head[k] = '0;
    foreach (l4_win[k]) l4_win[k] = '0;
  endfunction

  function automatic method_t head_method(input logic [47:0] text);
    if (text[47:24] == "GET") return METHOD_GET;
    if (text[47:24] == "PUT") return METHOD_PUT;
    if (text[47:16] == "POST") return METHOD_POST;
    if (text == "DELETE") return METHOD_DELETE;
    return METHOD_NONE;
  endfunction

  task automatic classify_byte(input logic [7:0] b, input logic is_last);
    int unsigned  p;
    int unsigned  l4_at;
    int unsigned  off;
    int unsigned  hdr_total;
    int unsigned  plen;
    logic [7:0]   want_proto;
    logic [47:0]  text;
    verdict_rec_t rec;
    p = frame_pos;
    case (p)
      12: eth_kind[15:8] = b;
      13: eth_kind[7:0] = b;
      14: ip_hdr_len = b[3:0] * 4;
      23: ip_proto = b;
      default: ;
    endcase
    if (p >= 26 && p <= 29) src_ip = {src_ip[23:0], b};
    if (p >= 30 && p <= 33) dst_ip = {dst_ip[23:0], b};
    l4_at = ETH_LEN + ip_hdr_len;
    if (p >= l4_at && p < l4_at + WIN_LEN) begin
      off = p - l4_at;
      l4_win[off] = b;
      case (off)
        0: src_port[15:8] = b;
        1: src_port[7:0] = b;
        2: dst_port[15:8] = b;
        3: dst_port[7:0] = b;
        12: l4_hdr_len = b[7:4] * 4;
        default: ;
      endcase
    end
    if (l4_hdr_len >= 16 && p >= l4_at + l4_hdr_len && p < l4_at + l4_hdr_len + HEAD_LEN) begin
      pay_head[p - l4_at - l4_hdr_len] = b;
    end
    if (frame_pos != '1) frame_pos++;
    if (is_last) begin
      // short transport header: payload begins inside the captured window
      if (l4_hdr_len < 16) begin
        for (int k = 0; k < HEAD_LEN; k++) pay_head[k] = l4_win[(l4_hdr_len + k) % WIN_LEN];
      end
      text = {pay_head[0], pay_head[1], pay_head[2], pay_head[3], pay_head[4], pay_head[5]};
      rec = '0;
      want_proto = sel_udp ? PROTO_UDP : PROTO_TCP;
      if (eth_kind != ETYPE_IPV4) begin
        rec.verdict = VERDICT_NOT_IPV4;
      end else if (ip_proto != want_proto) begin
        rec.verdict = VERDICT_WRONG_L4;
      end else begin
        rec.src_ip     = src_ip;
        rec.dst_ip     = dst_ip;
        rec.src_port   = src_port;
        rec.dst_port   = dst_port;
        rec.packet_num = accepted_num;
        hdr_total = ETH_LEN + ip_hdr_len + l4_hdr_len;
        plen = (frame_pos > hdr_total) ? frame_pos - hdr_total : 0;
        rec.payload_len = (plen > 32'hFFFF) ? 16'hFFFF : plen[15:0];
        if (plen == 0) begin
          rec.verdict = VERDICT_NO_PAYLOAD;
        end else if (!http_on) begin
          rec.verdict = VERDICT_NOT_FLAG;
        end else begin
          rec.method  = head_method(text);
          rec.verdict = VERDICT_NOT_FLAG;
          if (rec.method != METHOD_NONE &&
              (filter_code == FILTER_ALL || filter_code == rec.method)) begin
            rec.verdict = VERDICT_REQUEST;
            flagged_num++;
          end
          if (text[47:16] == "HTTP") begin
            rec.verdict = VERDICT_RESPONSE;
            flagged_num++;
          end
        end
        accepted_num++;
      end
      rec.flagged = flagged_num;
      expected_verdicts.push_back(rec);
      clear_frame_state();
    end
  endtask

  task automatic check_field(input string field_name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field_name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic compare_verdict(input verdict_rec_t want, input logic [OUT_DATA_BITS-1:0] raw);
    verdict_rec_t got;
    got = raw[$bits(verdict_rec_t)-1:0];
    check_field("verdict", want.verdict, got.verdict);
    check_field("method_code", want.method, got.method);
    check_field("source_ip", want.src_ip, got.src_ip);
    check_field("dest_ip", want.dst_ip, got.dst_ip);
    check_field("source_l4_port", want.src_port, got.src_port);
    check_field("dest_l4_port", want.dst_port, got.dst_port);
    check_field("payload_bytes", want.payload_len, got.payload_len);
    check_field("packet_number", want.packet_num, got.packet_num);
    check_field("flagged_total", want.flagged, got.flagged);
    check_field("padding", '0, raw[OUT_DATA_BITS-1:$bits(verdict_rec_t)]);
  endtask

  // Byte driver: hold the current transaction until taken, then advance or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        accepted_bytes++;
        classify_byte(in_tdata, in_tlast);
      end
      if (!in_tvalid || in_tready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_byte = pending_bytes.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= next_byte.value;
          in_tlast  <= next_byte.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Verdict monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_verdicts.size() == 0) begin
        $display("%0t: verdict mismatch: expected none, actual %0h", $time, out_tdata);
        mismatch_count++;
      end else begin
        compare_verdict(expected_verdicts.pop_front(), out_tdata);
      end
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d verdicts outstanding", $time, expected_verdicts.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic void poke(input int unsigned at, input logic [7:0] v);
    if (at < frame_buf.size()) frame_buf[at] = v;
  endfunction

  function automatic logic [47:0] payload_text(input payload_kind_t pick);
    case (pick)
      TEXT_GET:    return "GET / ";
      TEXT_PUT:    return "PUT / ";
      TEXT_POST:   return "POST /";
      TEXT_DELETE: return "DELETE";
      TEXT_HTTP:   return "HTTP/1";
      TEXT_NEAR: begin
        case ($urandom_range(5))
          0: return "GEt / ";
          1: return "PUX / ";
          2: return "POSt /";
          3: return "DELETx";
          4: return "HTTp/1";
          default: return "PO T /";
        endcase
      end
      default: return {$urandom, 16'($urandom)};
    endcase
  endfunction

  // Build one frame over random filler; cut truncates it to that many bytes
  task automatic push_frame(input logic [15:0] kind, input logic [7:0] proto,
                            input logic [3:0] ihl, input logic [3:0] doff,
                            input int unsigned pay_len, input logic [47:0] text,
                            input int unsigned cut);
    int unsigned l4_at;
    int unsigned pay_at;
    int unsigned total;
    l4_at  = ETH_LEN + ihl * 4;
    pay_at = l4_at + doff * 4;
    total  = pay_at + pay_len;
    if (cut != 0 && cut < total) total = cut;
    frame_buf.delete();
    repeat (total) frame_buf.push_back(8'($urandom));
    for (int k = 0; k < HEAD_LEN && k < pay_len; k++) poke(pay_at + k, text[47 - 8 * k -: 8]);
    poke(l4_at + 12, {doff, 4'($urandom)});
    poke(23, proto);
    poke(14, {4'h4, ihl});
    poke(12, kind[15:8]);
    poke(13, kind[7:0]);
    foreach (frame_buf[i]) begin
      pending_bytes.push_back('{value: frame_buf[i], last: (i == frame_buf.size() - 1)});
    end
    queued_bytes += frame_buf.size();
  endtask

  task automatic push_random_frame();
    int unsigned roll;
    int unsigned pay_len;
    logic [7:0]  want;
    logic [7:0]  proto;
    logic [15:0] kind;
    logic [3:0]  ihl;
    logic [3:0]  doff;
    want = sel_udp ? PROTO_UDP : PROTO_TCP;
    roll = $urandom_range(99);
    kind = (roll < 80) ? ETYPE_IPV4 : 16'($urandom);
    roll = $urandom_range(99);
    proto = (roll < 80) ? want : (roll < 90) ? (sel_udp ? PROTO_TCP : PROTO_UDP) : 8'($urandom);
    ihl  = ($urandom_range(3) == 0) ? 4'($urandom) : 4'd5;
    doff = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(8, 5));
    pay_len = ($urandom_range(4) == 0) ? 0 : $urandom_range(12, 1);
    push_frame(kind, proto, ihl, doff, pay_len, payload_text(payload_kind_t'($urandom_range(6))),
               ($urandom_range(9) == 0) ? $urandom_range(80, 1) : 0);
  endtask

  task automatic wait_idle();
    while (accepted_bytes != queued_bytes || expected_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Idle mix of sender and receiver
  task automatic set_phase(input int unsigned phase);
    case (phase)
      0: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct = 53;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;
        recv_stall_pct = 53;
      end
      default: begin
        send_idle_pct = 31;
        recv_stall_pct = 31;
      end
    endcase
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [2:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_TRANSPORT: sel_udp = value[0];
      CFG_HTTP_EN:   http_on = value[0];
      default:       filter_code = value;
    endcase
    @(posedge clk);
  endtask

  // Single-bit registers get noise in the unused upper bits
  task automatic configure(input logic udp, input logic http, input logic [2:0] filter);
    wait_idle();
    write_reg(CFG_TRANSPORT, {2'($urandom), udp});
    write_reg(CFG_HTTP_EN, {2'($urandom), http});
    write_reg(CFG_METHOD, filter);
  endtask

  initial begin
    logic [2:0] filter;
    clear_frame_state();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    configure(1'b0, 1'b0, FILTER_ALL);
    set_phase(0);
    push_frame(16'hFFFF, 8'hFF, 4'hF, 4'hF, 0, payload_text(TEXT_RANDOM), 1);
    push_frame(16'h0000, 8'h00, 4'h0, 4'h0, 0, payload_text(TEXT_RANDOM), 13);
    push_frame(16'h86DD, PROTO_TCP, 4'd0, 4'd4, 6, payload_text(TEXT_GET), 0);
    push_frame(ETYPE_IPV4, PROTO_UDP, 4'd0, 4'd4, 6, payload_text(TEXT_GET), 0);
    push_frame(ETYPE_IPV4, PROTO_TCP, 4'd0, 4'd4, 0, payload_text(TEXT_RANDOM), 0);
    push_frame(ETYPE_IPV4, PROTO_TCP, 4'd0, 4'd4, 6, payload_text(TEXT_GET), 0);
    // frame ends right after the protocol byte
    push_frame(ETYPE_IPV4, PROTO_TCP, 4'd5, 4'd5, 0, payload_text(TEXT_RANDOM), 24);

    configure(1'b0, 1'b1, FILTER_ALL);
    set_phase(1);
    for (int k = TEXT_GET; k <= TEXT_NEAR; k++) begin
      push_frame(ETYPE_IPV4, PROTO_TCP, 4'd0, 4'd4, 6, payload_text(payload_kind_t'(k)), 0);
    end
    push_frame(ETYPE_IPV4, PROTO_TCP, 4'd5, 4'd2, 10, payload_text(TEXT_POST), 0);
    push_frame(ETYPE_IPV4, PROTO_TCP, 4'd5, 4'd0, 10, payload_text(TEXT_GET), 0);
    push_frame(ETYPE_IPV4, PROTO_TCP, 4'd15, 4'd15, 6, payload_text(TEXT_HTTP), 0);
    push_frame(ETYPE_IPV4, PROTO_TCP, 4'd0, 4'd5, 10, payload_text(TEXT_DELETE), 0);
    // payload shorter than the method word: missing bytes read as zero
    push_frame(ETYPE_IPV4, PROTO_TCP, 4'd0, 4'd4, 2, payload_text(TEXT_GET), 0);

    configure(1'b0, 1'b1, METHOD_POST);
    set_phase(2);
    push_frame(ETYPE_IPV4, PROTO_TCP, 4'd0, 4'd4, 6, payload_text(TEXT_GET), 0);
    push_frame(ETYPE_IPV4, PROTO_TCP, 4'd0, 4'd4, 6, payload_text(TEXT_POST), 0);

    configure(1'b1, 1'b1, FILTER_OFF);
    set_phase(3);
    push_frame(ETYPE_IPV4, PROTO_UDP, 4'd5, 4'd2, 12, payload_text(TEXT_DELETE), 0);
    push_frame(ETYPE_IPV4, PROTO_UDP, 4'd0, 4'd4, 6, payload_text(TEXT_HTTP), 0);
    push_frame(ETYPE_IPV4, PROTO_TCP, 4'd0, 4'd4, 6, payload_text(TEXT_GET), 0);

    for (int seg = 0; seg < 4; seg++) begin
      case (seg)
        0: filter = FILTER_ALL;
        1: filter = METHOD_DELETE;
        2: filter = FILTER_OFF;
        default: filter = 3'($urandom);
      endcase
      configure(1'(seg / 2), seg != 2, filter);
      set_phase(seg);
      push_random_frame();
    end
    wait_idle();

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
